// ===== hw/rtl/kded_pkg.sv =====
// Shared constants, field layout and lookup tables of the keypad digit entry block.
`timescale 1ns / 1ps
`default_nettype none

package kded_pkg;

  localparam int unsigned KeyW    = 16;
  localparam int unsigned SegW    = 8;
  localparam int unsigned EnW     = 4;
  localparam int unsigned CodeW   = 4;
  localparam int unsigned CurW    = 3;
  localparam int unsigned CfgW    = 16;
  localparam int unsigned AddrW   = 3;
  localparam int unsigned DataW   = 32;

  localparam int unsigned SegLsb  = 0;
  localparam int unsigned EnLsb   = SegLsb + SegW;
  localparam int unsigned CodeLsb = EnLsb + EnW;
  localparam int unsigned CurLsb  = CodeLsb + CodeW;
  localparam int unsigned OutW    = 24;

  localparam logic [CfgW-1:0]  SettleReset = 16'd200;
  localparam logic [CfgW-1:0]  DwellReset  = 16'd200;
  localparam logic [CodeW-1:0] CodePoint   = 4'd10;
  localparam logic [CurW-1:0]  CursorTop   = 3'd4;

  typedef logic [CodeW-1:0] code_t;
  typedef logic [SegW-1:0]  seg_t;

  function automatic code_t key_to_code(input logic [3:0] key);
    code_t c;
    case (key)
      4'd0:    c = 4'd1;
      4'd1:    c = 4'd4;
      4'd2:    c = 4'd7;
      4'd3:    c = 4'd14;
      4'd4:    c = 4'd2;
      4'd5:    c = 4'd5;
      4'd6:    c = 4'd8;
      4'd7:    c = 4'd0;
      4'd8:    c = 4'd3;
      4'd9:    c = 4'd6;
      4'd10:   c = 4'd9;
      4'd11:   c = 4'd15;
      4'd12:   c = 4'd10;
      4'd13:   c = 4'd11;
      4'd14:   c = 4'd12;
      default: c = 4'd13;
    endcase
    return c;
  endfunction

  function automatic seg_t code_to_seg(input code_t code);
    seg_t s;
    case (code)
      4'd0:    s = 8'h3F;
      4'd1:    s = 8'h06;
      4'd2:    s = 8'h5B;
      4'd3:    s = 8'h4F;
      4'd4:    s = 8'h66;
      4'd5:    s = 8'h6D;
      4'd6:    s = 8'h7D;
      4'd7:    s = 8'h07;
      4'd8:    s = 8'h7F;
      4'd9:    s = 8'h67;
      4'd10:   s = 8'h80;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/keypad_digit_entry_display.sv =====
// Top level of the keypad digit entry block with four-digit display multiplexing.
//
// Each input transaction on the s_axis channel carries one 16-bit active-low
// snapshot of the 4x4 key matrix and counts as one tick. For every input
// transaction exactly one output transaction follows on the m_axis channel,
// carrying the segment pattern and one-hot digit enable shown during that
// tick, the completed key release (tuser) with its code, and the cursor.
// The settle and dwell tick counts are written over the APB port at byte
// addresses 0 and 4; configure only while no transaction is in flight.
// An input transaction is captured in an input register, and then the key
// scan, entry and display step updates the state and loads the output
// register. A new input transaction is taken every cycle as long as the
// output side drains; throughput is one tick per cycle, set by the single
// update step. When the receiver stalls, the output holds its transaction,
// the input register fills, and s_axis_tready drops until the output is
// taken. Reset clears the scan state, the digit store and the display
// position, sets the cursor to four and both tick counts to 200.
`timescale 1ns / 1ps
`default_nettype none

module keypad_digit_entry_display (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          s_axis_tvalid,
  output logic                         s_axis_tready,
  input  wire  [kded_pkg::KeyW-1:0]    s_axis_tdata,   // key_matrix
  output logic                         m_axis_tvalid,
  input  wire                          m_axis_tready,
  // segments, digit_enable, key_code, cursor_now, zero fill
  output logic [kded_pkg::OutW-1:0]    m_axis_tdata,
  output logic                         m_axis_tuser,   // key_event
  input  wire                          psel,
  input  wire                          penable,
  input  wire                          pwrite,
  input  wire  [kded_pkg::AddrW-1:0]   paddr,
  input  wire  [kded_pkg::DataW-1:0]   pwdata,
  output logic [kded_pkg::DataW-1:0]   prdata,
  output logic                         pready
);
  import kded_pkg::*;

  typedef enum logic [1:0] {
    ModeIdle,
    ModeSettle,
    ModeRelease
  } mode_e;

  logic [CfgW-1:0]  settle_ticks_q, dwell_ticks_q;
  logic             cfg_wr;

  logic             in_valid_q;
  logic [KeyW-1:0]  in_keys_q;
  logic             advance;

  mode_e            mode_q, mode_d;
  logic [3:0]       held_q, held_d;
  logic [CfgW-1:0]  settle_cnt_q, settle_cnt_d;
  code_t            store_q [4];
  code_t            store_d [4];
  logic [CurW-1:0]  cursor_q, cursor_d;
  logic [1:0]       mux_q, mux_d;
  logic [CfgW-1:0]  dwell_cnt_q, dwell_cnt_d;

  logic [1:0]       slot_idx;
  seg_t             segs;
  logic [EnW-1:0]   enable;
  logic             event_d;
  code_t            code_d;
  logic             found;
  logic [3:0]       first_key;
  code_t            held_code;
  logic [CfgW-1:0]  limit;
  logic [CfgW-1:0]  dwell_inc;

  logic [OutW-1:0]  out_data_q;
  logic             out_user_q;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    if (paddr[2]) begin
      prdata = {{(DataW-CfgW){1'b0}}, dwell_ticks_q};
    end else begin
      prdata = {{(DataW-CfgW){1'b0}}, settle_ticks_q};
    end
  end

  assign advance       = in_valid_q && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  assign slot_idx  = 2'd3 - mux_q;
  assign segs      = code_to_seg(store_q[slot_idx]);
  assign enable    = EnW'(1) << slot_idx;
  assign held_code = key_to_code(held_q);
  assign limit     = (dwell_ticks_q == '0) ? CfgW'(1) : dwell_ticks_q;
  assign dwell_inc = dwell_cnt_q + CfgW'(1);

  always_comb begin
    found     = 1'b0;
    first_key = '0;
    for (int b = 0; b < KeyW; b++) begin
      if (!found && !in_keys_q[b]) begin
        found     = 1'b1;
        first_key = 4'(b);
      end
    end
  end

  always_comb begin
    mode_d       = mode_q;
    held_d       = held_q;
    settle_cnt_d = settle_cnt_q;
    cursor_d     = cursor_q;
    store_d      = store_q;
    event_d      = 1'b0;
    code_d       = '0;
    case (mode_q)
      ModeSettle: begin
        if (settle_cnt_q >= settle_ticks_q) begin
          mode_d = ModeRelease;
        end else begin
          settle_cnt_d = settle_cnt_q + CfgW'(1);
        end
      end
      ModeRelease: begin
        if (in_keys_q[held_q]) begin
          event_d = 1'b1;
          code_d  = held_code;
          mode_d  = ModeIdle;
          if (held_code != CodePoint) begin
            if (cursor_q == '0) begin
              cursor_d = CursorTop;
            end else begin
              if (cursor_q <= CursorTop) begin
                store_d[2'(cursor_q - CurW'(1))] = held_code;
              end
              cursor_d = cursor_q - CurW'(1);
            end
          end
        end
      end
      default: begin
        mode_d = ModeIdle;
        if (found) begin
          held_d       = first_key;
          settle_cnt_d = '0;
          mode_d       = ModeSettle;
        end
      end
    endcase
  end

  always_comb begin
    mux_d       = mux_q;
    dwell_cnt_d = dwell_inc;
    if (dwell_inc >= limit || dwell_inc == '0) begin
      dwell_cnt_d = '0;
      mux_d       = mux_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settle_ticks_q <= SettleReset;
      dwell_ticks_q  <= DwellReset;
    end else if (cfg_wr) begin
      if (paddr[2]) begin
        dwell_ticks_q <= pwdata[CfgW-1:0];
      end else begin
        settle_ticks_q <= pwdata[CfgW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_keys_q <= s_axis_tdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= ModeIdle;
      held_q       <= '0;
      settle_cnt_q <= '0;
      store_q      <= '{default: '0};
      cursor_q     <= CursorTop;
      mux_q        <= '0;
      dwell_cnt_q  <= '0;
    end else if (advance) begin
      mode_q       <= mode_d;
      held_q       <= held_d;
      settle_cnt_q <= settle_cnt_d;
      store_q      <= store_d;
      cursor_q     <= cursor_d;
      mux_q        <= mux_d;
      dwell_cnt_q  <= dwell_cnt_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= {{(OutW-CurLsb-CurW){1'b0}}, cursor_d, code_d, enable, segs};
      out_user_q <= event_d;
    end
  end

  assign m_axis_tdata = out_data_q;
  assign m_axis_tuser = out_user_q;

endmodule

`default_nettype wire

// ===== hw/rtl/kded_checker.sv =====
// Port-level checker of the keypad digit entry block and its bind statement.
`timescale 1ns / 1ps
`default_nettype none

module kded_checker (
  input wire                        clk_i,
  input wire                        rst_ni,
  input wire                        m_axis_tvalid,
  input wire                        m_axis_tready,
  input wire [kded_pkg::OutW-1:0]   m_axis_tdata,
  input wire                        m_axis_tuser
);
  import kded_pkg::*;

  logic [EnW-1:0]   enable;
  logic [CodeW-1:0] code;
  logic [CurW-1:0]  cursor;

  assign enable = m_axis_tdata[EnLsb +: EnW];
  assign code   = m_axis_tdata[CodeLsb +: CodeW];
  assign cursor = m_axis_tdata[CurLsb +: CurW];

  a_enable_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> $onehot(enable))
    else $error("digit enable is not one-hot");

  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> cursor <= CursorTop)
    else $error("cursor out of range");

  a_code_without_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |-> code == '0)
    else $error("key code set without a key event");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("output transaction changed while stalled");

endmodule

bind keypad_digit_entry_display kded_checker u_kded_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

// ===== tb/tb_keypad_digit_entry_display.sv =====
// Self-checking testbench for the keypad digit entry and display block.
`timescale 1ns / 1ps

module tb_keypad_digit_entry_display;
  import kded_pkg::*;

  typedef enum logic [1:0] {ScanIdle, ScanSettle, ScanRelease} scan_mode_e;
  typedef enum int unsigned {ReadyFull, ReadyHalf, ReadySparse, ReadyHold} ready_style_e;
  typedef enum int unsigned {StrokeNoise, StrokeShort, StrokeFull} stroke_e;

  typedef struct packed {
    logic [SegW-1:0]  segments;
    logic [EnW-1:0]   digit_enable;
    logic             key_event;
    logic [CodeW-1:0] key_code;
    logic [CurW-1:0]  cursor_now;
  } display_tick_t;

  localparam logic [AddrW-1:0] AddrSettle = 3'd0;
  localparam logic [AddrW-1:0] AddrDwell  = 3'd4;
  localparam int unsigned NumDirected = 25;
  localparam int unsigned NumPhases   = 8;
  localparam int unsigned DrainLimit  = 5000;

  // Key code of matrix bit b sits at bits 4*b+3:4*b.
  localparam logic [63:0] KeyCodeMap = {4'd13, 4'd12, 4'd11, 4'd10, 4'd15, 4'd9, 4'd6, 4'd3,
                                        4'd0, 4'd8, 4'd5, 4'd2, 4'd14, 4'd7, 4'd4, 4'd1};
  // Segment pattern of code c sits at bits 8*c+7:8*c.
  localparam logic [127:0] SegMap = {8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h80, 8'h67, 8'h7F,
                                     8'h07, 8'h7D, 8'h6D, 8'h66, 8'h4F, 8'h5B, 8'h06, 8'h3F};

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  wire                  s_axis_tready;
  logic [KeyW-1:0]      s_axis_tdata = '1;   // key_matrix
  wire                  m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  // segments, digit_enable, key_code, cursor_now, zero fill
  wire  [OutW-1:0]      m_axis_tdata;
  wire                  m_axis_tuser;        // key_event
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [AddrW-1:0]     paddr = '0;
  logic [DataW-1:0]     pwdata = '0;
  wire  [DataW-1:0]     prdata;
  wire                  pready;

  // Directed rows run with settle and dwell of zero, so the display advances every tick.
  logic [KeyW-1:0] dir_keys [NumDirected] = '{
    16'hFFFF, 16'hFFFE, 16'hFFFE, 16'hFFFF, 16'h0000, 16'h0000, 16'hFFFE, 16'h0001,
    16'h7FFF, 16'h0000, 16'hFFFF, 16'hEFFF, 16'hEFFF, 16'hFFFF, 16'hF7FF, 16'hF7FF,
    16'hFFFF, 16'hFF7F, 16'hFF7F, 16'hFFFF, 16'hFFDF, 16'hFFDF, 16'hFFFF, 16'hFFFF,
    16'hFFFF};
  logic dir_typed [NumDirected] = '{
    1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
    1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0};
  display_tick_t dir_want [NumDirected] = '{
    {8'h3F, 4'b1000, 1'b0, 4'd0, 3'd4}, '0, '0, {8'h3F, 4'b0001, 1'b1, 4'd1, 3'd3},
    '0, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0};

  logic [CfgW-1:0] phase_settle [NumPhases] = '{16'd0, 16'd65535, 16'd1, 16'd3,
                                                16'd2, 16'd7, 16'd200, 16'd5};
  logic [CfgW-1:0] phase_dwell [NumPhases]  = '{16'd0, 16'd65535, 16'd1, 16'd2,
                                                16'd65535, 16'd5, 16'd200, 16'd3};
  int unsigned     phase_items [NumPhases]  = '{250, 40, 200, 180, 150, 150, 230, 120};

  logic [CfgW-1:0]  settle_cfg;
  logic [CfgW-1:0]  dwell_cfg;
  scan_mode_e       scan_mode;
  logic [3:0]       held_bit;
  logic [CfgW-1:0]  settle_cnt;
  logic [CfgW-1:0]  dwell_cnt;
  logic [CodeW-1:0] digits [4];
  logic [CurW-1:0]  cursor;
  logic [1:0]       mux_pos;

  display_tick_t    expected_ticks [$];
  int unsigned      mismatch_count = 0;
  int unsigned      ticks_sent = 0;
  int unsigned      ticks_seen = 0;
  int unsigned      releases_seen = 0;
  int unsigned      point_keys_seen = 0;
  int unsigned      settings_used = 0;
  int unsigned      burst_left = 0;

  keypad_digit_entry_display i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  task automatic flag_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic clear_keypad_model();
    settle_cfg = SettleReset;
    dwell_cfg  = DwellReset;
    scan_mode  = ScanIdle;
    held_bit   = '0;
    settle_cnt = '0;
    dwell_cnt  = '0;
    for (int i = 0; i < 4; i++) digits[i] = '0;
    cursor     = CursorTop;
    mux_pos    = '0;
  endtask

  // Advances the keypad state by one tick and returns the output transaction it causes.
  function automatic display_tick_t step_keypad(input logic [KeyW-1:0] keys);
    display_tick_t   r;
    logic [1:0]      slot_idx;
    logic [CfgW-1:0] lim;
    logic            found;
    slot_idx       = 2'd3 - mux_pos;
    r.segments     = SegMap[8*digits[slot_idx] +: 8];
    r.digit_enable = 4'b0001 << slot_idx;
    r.key_event    = 1'b0;
    r.key_code     = '0;
    case (scan_mode)
      ScanSettle: begin
        if (settle_cnt >= settle_cfg) scan_mode = ScanRelease;
        else settle_cnt = settle_cnt + 1'b1;
      end
      ScanRelease: begin
        if (keys[held_bit]) begin
          r.key_event = 1'b1;
          r.key_code  = KeyCodeMap[4*held_bit +: 4];
          scan_mode   = ScanIdle;
          if (r.key_code != CodePoint) begin
            if (cursor == '0) begin
              cursor = CursorTop;
            end else begin
              if (cursor <= CursorTop) digits[2'(cursor - 1'b1)] = r.key_code;
              cursor = cursor - 1'b1;
            end
          end
        end
      end
      default: begin
        found     = 1'b0;
        scan_mode = ScanIdle;
        for (int b = 0; b < KeyW; b++) begin
          if (!found && !keys[b]) begin
            found      = 1'b1;
            held_bit   = 4'(b);
            settle_cnt = '0;
            scan_mode  = ScanSettle;
          end
        end
      end
    endcase
    lim = (dwell_cfg == '0) ? 16'd1 : dwell_cfg;
    dwell_cnt = dwell_cnt + 1'b1;
    if (dwell_cnt >= lim || dwell_cnt == '0) begin
      dwell_cnt = '0;
      mux_pos   = mux_pos + 1'b1;
    end
    r.cursor_now = cursor;
    return r;
  endfunction

  task automatic apb_transfer(input logic write, input logic [AddrW-1:0] addr,
                              input logic [DataW-1:0] wdata, output logic [DataW-1:0] rdata);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= addr;
    pwdata  <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rdata = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic check_register(input logic [AddrW-1:0] addr, input logic [CfgW-1:0] want);
    logic [DataW-1:0] rdata;
    apb_transfer(1'b0, addr, '0, rdata);
    if (rdata !== {{(DataW-CfgW){1'b0}}, want})
      flag_mismatch($sformatf("register at %0d reads %h, expected %h", addr, rdata, want));
  endtask

  task automatic set_register(input logic [AddrW-1:0] addr, input logic [CfgW-1:0] value);
    logic [DataW-1:0] unused;
    apb_transfer(1'b1, addr, {{(DataW-CfgW){1'b0}}, value}, unused);
    if (addr == AddrSettle) settle_cfg = value;
    else dwell_cfg = value;
    check_register(addr, value);
  endtask

  // The sender moves in bursts; between bursts tvalid may drop for a random gap.
  task automatic send_matrix(input logic [KeyW-1:0] keys, input logic typed,
                             input display_tick_t want);
    int unsigned   gap;
    display_tick_t predicted;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk_i);
        s_axis_tvalid <= 1'b0;
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= keys;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predicted = step_keypad(keys);
    expected_ticks.push_back(typed ? want : predicted);
    ticks_sent++;
  endtask

  task automatic finish_phase();
    int unsigned waited;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    waited = 0;
    while (expected_ticks.size() != 0 && waited < DrainLimit) begin
      @(posedge clk_i);
      waited++;
    end
    if (expected_ticks.size() != 0) begin
      flag_mismatch($sformatf("%0d output transactions never arrived", expected_ticks.size()));
      expected_ticks.delete();
    end
    repeat (4) @(posedge clk_i);
  endtask

  // Mostly complete keystrokes: press, hold through the settle time, release.
  task automatic play_phase(input int unsigned n_items);
    int unsigned     sent;
    int unsigned     hold;
    logic [3:0]      b;
    int unsigned     pick;
    stroke_e         kind;
    logic [KeyW-1:0] keys;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(0, 9);
      kind = (pick == 0) ? StrokeNoise : (pick == 1) ? StrokeShort : StrokeFull;
      b    = 4'($urandom_range(0, KeyW - 1));
      keys = 16'($urandom_range(0, 16'hFFFF));
      if (kind == StrokeNoise) begin
        send_matrix(keys, 1'b0, '0);
        sent++;
      end else begin
        if ($urandom_range(0, 2) == 0) keys = '1;
        keys    = keys | ((16'd1 << b) - 16'd1);
        keys[b] = 1'b0;
        send_matrix(keys, 1'b0, '0);
        sent++;
        hold = 32'(settle_cfg);
        hold = (kind == StrokeShort) ? $urandom_range(0, hold) : hold + 1 + $urandom_range(0, 3);
        while (hold > 0 && sent < n_items) begin
          keys    = 16'($urandom_range(0, 16'hFFFF));
          keys[b] = 1'b0;
          send_matrix(keys, 1'b0, '0);
          sent++;
          hold--;
        end
        if (sent < n_items) begin
          keys    = 16'($urandom_range(0, 16'hFFFF));
          keys[b] = 1'b1;
          send_matrix(keys, 1'b0, '0);
          sent++;
        end
        repeat ($urandom_range(0, 2)) begin
          if (sent < n_items) begin
            send_matrix('1, 1'b0, '0);
            sent++;
          end
        end
      end
    end
  endtask

  initial begin : ready_pattern
    ready_style_e style;
    int unsigned  span;
    forever begin
      style = ready_style_e'($urandom_range(0, 3));
      span  = (style == ReadyHold) ? $urandom_range(1, 8) : $urandom_range(4, 40);
      repeat (span) begin
        @(negedge clk_i);
        case (style)
          ReadyFull:   m_axis_tready <= 1'b1;
          ReadyHalf:   m_axis_tready <= 1'($urandom_range(0, 1));
          ReadySparse: m_axis_tready <= ($urandom_range(0, 3) == 0);
          default:     m_axis_tready <= 1'b0;
        endcase
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    display_tick_t got;
    display_tick_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.segments     = m_axis_tdata[SegLsb +: SegW];
      got.digit_enable = m_axis_tdata[EnLsb +: EnW];
      got.key_event    = m_axis_tuser;
      got.key_code     = m_axis_tdata[CodeLsb +: CodeW];
      got.cursor_now   = m_axis_tdata[CurLsb +: CurW];
      if (expected_ticks.size() == 0) begin
        flag_mismatch($sformatf("output transaction %0d arrived with none expected", ticks_seen));
      end else begin
        want = expected_ticks.pop_front();
        if (got.segments !== want.segments)
          flag_mismatch($sformatf("tick %0d segments %h, expected %h",
                                  ticks_seen, got.segments, want.segments));
        if (got.digit_enable !== want.digit_enable)
          flag_mismatch($sformatf("tick %0d digit_enable %b, expected %b",
                                  ticks_seen, got.digit_enable, want.digit_enable));
        if (got.key_event !== want.key_event)
          flag_mismatch($sformatf("tick %0d key_event %b, expected %b",
                                  ticks_seen, got.key_event, want.key_event));
        if (got.key_code !== want.key_code)
          flag_mismatch($sformatf("tick %0d key_code %0d, expected %0d",
                                  ticks_seen, got.key_code, want.key_code));
        if (got.cursor_now !== want.cursor_now)
          flag_mismatch($sformatf("tick %0d cursor_now %0d, expected %0d",
                                  ticks_seen, got.cursor_now, want.cursor_now));
        if (m_axis_tdata[OutW-1:CurLsb+CurW] !== '0)
          flag_mismatch($sformatf("tick %0d fill bits of tdata are %h",
                                  ticks_seen, m_axis_tdata[OutW-1:CurLsb+CurW]));
      end
      if (got.key_event === 1'b1) releases_seen++;
      if (got.key_event === 1'b1 && got.key_code == CodePoint) point_keys_seen++;
      ticks_seen++;
    end
  end

  initial begin
    clear_keypad_model();
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    check_register(AddrSettle, SettleReset);
    check_register(AddrDwell, DwellReset);
    set_register(AddrSettle, '0);
    set_register(AddrDwell, '0);
    settings_used++;
    for (int i = 0; i < NumDirected; i++) send_matrix(dir_keys[i], dir_typed[i], dir_want[i]);
    finish_phase();

    for (int p = 0; p < NumPhases; p++) begin
      set_register(AddrSettle, phase_settle[p]);
      set_register(AddrDwell, phase_dwell[p]);
      settings_used++;
      play_phase(phase_items[p]);
      finish_phase();
    end

    $display("Sent %0d key matrix snapshots under %0d settle/dwell settings, checked %0d outputs.",
             ticks_sent, settings_used, ticks_seen);
    $display("Key releases observed: %0d (%0d of them the point key); mismatches: %0d.",
             releases_seen, point_keys_seen, mismatch_count);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== keypad_digit_entry_display.f =====
hw/rtl/kded_pkg.sv
hw/rtl/keypad_digit_entry_display.sv
hw/rtl/kded_checker.sv
tb/tb_keypad_digit_entry_display.sv
